// File: sv/mqrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqrf_pkg
// Shared types and constants of the multi-queue ring FIFO: item kinds,
// status codes, register indexes and the control group between modules.
// ----------------------------------------------------------------------------
package mqrf_pkg;

   // default sizes
   localparam int NUM_QUEUES_DEF = 4;
   localparam int MAX_DEPTH_DEF  = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed field widths
   localparam int QUEUE_ID_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;
   localparam int ENABLE_W    = 4;
   localparam int DEPTH_REG_W = 5;

   // depth registers exist for this many queues
   localparam int NUM_CSR_QUEUES = 4;

   // reset value of every depth register
   localparam int DEPTH_RESET = 16;

   // item kinds
   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_RECV = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_BASE = 3'd1;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DISABLED = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // control group from the queue bookkeeping to the store and pipeline
   typedef struct packed {
      logic       mem_en;
      logic       mem_we;
      logic       rd_ok;
      status_type status;
   } op_type;

endpackage
`default_nettype wire

// File: sv/mqrf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqrf_ram
// Generic single-port synchronous RAM with registered read data; read data
// holds while the port is not enabled for a read.
// ----------------------------------------------------------------------------
module mqrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write or registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: sv/mqrf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mqrf_ctrl
// Per-queue bookkeeping: enable mask, depths, read and write pointers and
// fill counts. Decides each item's status and drives the shared store.
// ----------------------------------------------------------------------------
module mqrf_ctrl #(
   parameter int NUM_QUEUES = mqrf_pkg::NUM_QUEUES_DEF,
   parameter int MAX_DEPTH  = mqrf_pkg::MAX_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic                                req_kind,
   input  wire logic [mqrf_pkg::QUEUE_ID_W-1:0]     req_queue_id,
   input  wire logic                                csr_we,
   input  wire logic [mqrf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mqrf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mqrf_pkg::op_type                         op,
   output logic [$clog2(MAX_DEPTH+1)-1:0]           level,
   output logic [$clog2(NUM_QUEUES*MAX_DEPTH)-1:0]  addr
);
   import mqrf_pkg::*;

   localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W  = $clog2(MAX_DEPTH);
   localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_QUEUES * MAX_DEPTH);
   localparam int DEPTH_INIT = (DEPTH_RESET > MAX_DEPTH) ? MAX_DEPTH : DEPTH_RESET;

   logic [ENABLE_W-1:0] enable_ff, enable_in;
   logic [CNT_W-1:0]    depth_ff [NUM_QUEUES];
   logic [CNT_W-1:0]    depth_in [NUM_QUEUES];
   logic [PTR_W-1:0]    wp_ff [NUM_QUEUES];
   logic [PTR_W-1:0]    wp_in [NUM_QUEUES];
   logic [PTR_W-1:0]    rp_ff [NUM_QUEUES];
   logic [PTR_W-1:0]    rp_in [NUM_QUEUES];
   logic [CNT_W-1:0]    cnt_ff [NUM_QUEUES];
   logic [CNT_W-1:0]    cnt_in [NUM_QUEUES];

   logic [QIDX_W-1:0] qsel;
   logic              q_hit;
   logic [CNT_W-1:0]  cur_depth;
   logic [CNT_W-1:0]  cur_cnt;
   logic [PTR_W-1:0]  cur_wp;
   logic [PTR_W-1:0]  cur_rp;
   logic [PTR_W-1:0]  cur_ptr;
   logic              send_ok;
   logic              recv_ok;
   logic              wp_wrap;
   logic              rp_wrap;
   logic [31:0]       wval;
   logic [CNT_W-1:0]  depth_wr;

   // look up the addressed queue
   always_comb begin
      qsel  = QIDX_W'(req_queue_id);
      q_hit = (32'(req_queue_id) < NUM_QUEUES) && enable_ff[req_queue_id];
      cur_depth = q_hit ? depth_ff[qsel] : CNT_W'(1);
      cur_cnt   = q_hit ? cnt_ff[qsel]   : '0;
      cur_wp    = q_hit ? wp_ff[qsel]    : '0;
      cur_rp    = q_hit ? rp_ff[qsel]    : '0;
      send_ok = q_hit && (req_kind == KIND_SEND) && (cur_cnt < cur_depth);
      recv_ok = q_hit && (req_kind == KIND_RECV) && (cur_cnt != '0);
      wp_wrap = (CNT_W'(cur_wp) + CNT_W'(1)) >= cur_depth;
      rp_wrap = (CNT_W'(cur_rp) + CNT_W'(1)) >= cur_depth;
      cur_ptr = (req_kind == KIND_SEND) ? cur_wp : cur_rp;
   end

   // status, level and store access for this item
   always_comb begin
      op.mem_en = accept && (send_ok || recv_ok);
      op.mem_we = send_ok;
      op.rd_ok  = recv_ok;
      if (!q_hit) begin
         op.status = ST_DISABLED;
      end else if (req_kind == KIND_SEND) begin
         op.status = send_ok ? ST_OK : ST_FULL;
      end else begin
         op.status = recv_ok ? ST_OK : ST_EMPTY;
      end
      if (send_ok) begin
         level = cur_cnt + CNT_W'(1);
      end else if (recv_ok) begin
         level = cur_cnt - CNT_W'(1);
      end else begin
         level = cur_cnt;
      end
      addr = ADDR_W'(qsel) * ADDR_W'(MAX_DEPTH) + ADDR_W'(cur_ptr);
   end

   // clamp a written depth into 1 .. MAX_DEPTH
   always_comb begin
      wval = 32'(csr_wdata);
      if (wval == 32'd0) begin
         depth_wr = CNT_W'(1);
      end else if (wval > 32'(MAX_DEPTH)) begin
         depth_wr = CNT_W'(MAX_DEPTH);
      end else begin
         depth_wr = CNT_W'(wval);
      end
   end

   // next pointer, count and register values
   always_comb begin
      enable_in = enable_ff;
      depth_in  = depth_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      cnt_in    = cnt_ff;
      if (accept && send_ok) begin
         wp_in[qsel]  = wp_wrap ? '0 : cur_wp + PTR_W'(1);
         cnt_in[qsel] = level;
      end
      if (accept && recv_ok) begin
         rp_in[qsel]  = rp_wrap ? '0 : cur_rp + PTR_W'(1);
         cnt_in[qsel] = level;
      end
      if (csr_we && csr_index == CSR_ENABLE) begin
         enable_in = csr_wdata[ENABLE_W-1:0];
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
         if (q < NUM_CSR_QUEUES) begin
            // a rising enable bit or any depth write recreates the queue
            if ((csr_we && csr_index == CSR_ENABLE && csr_wdata[q] && !enable_ff[q]) ||
                (csr_we && csr_index == CSR_DEPTH_BASE + CSR_INDEX_W'(q))) begin
               wp_in[q]  = '0;
               rp_in[q]  = '0;
               cnt_in[q] = '0;
            end
            if (csr_we && csr_index == CSR_DEPTH_BASE + CSR_INDEX_W'(q)) begin
               depth_in[q] = depth_wr;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            depth_ff[q] <= CNT_W'(DEPTH_INIT);
            wp_ff[q]    <= '0;
            rp_ff[q]    <= '0;
            cnt_ff[q]   <= '0;
         end
      end else begin
         enable_ff <= enable_in;
         depth_ff  <= depth_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/multi_queue_ring_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_queue_ring_fifo
// Up to NUM_QUEUES circular message queues sharing one word store. Each
// item is a send or a receive on one queue; each gives one result item.
//
// Use: an item on req_ (kind, queue_id, payload) is taken when req_valid and
// req_ready are high. Its result passes the stage and output registers to
// rsp_ (status, read_data, fill_level) and holds until rsp_ready is high.
// Throughput is one item per cycle while req_ready stays high: status,
// pointers and fill counts are settled in the cycle of acceptance from
// per-queue registers, and the word store, a single-port RAM with
// registered read data, is written or read in that same cycle. A receive
// following a send to the same queue in the next cycle sees the new word
// since the write has completed. A stage register and an output register
// sit between the two sides, so an item is still taken while one result
// waits; when the receiver stalls, req_ready drops once both are full.
// Configuration goes through csr_we, csr_index and csr_wdata; it must be
// written only while no item is in flight, which the block itself does
// not enforce. Enabling a queue or writing its depth empties that queue.
// After reset every queue is disabled and empty at depth min(16, MAX_DEPTH).
// ----------------------------------------------------------------------------
module multi_queue_ring_fifo #(
   parameter int NUM_QUEUES = mqrf_pkg::NUM_QUEUES_DEF,
   parameter int MAX_DEPTH  = mqrf_pkg::MAX_DEPTH_DEF,
   parameter int DATA_WIDTH = mqrf_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // item input
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_kind,
   input  wire logic [mqrf_pkg::QUEUE_ID_W-1:0]  req_queue_id,
   input  wire logic [DATA_WIDTH-1:0]            req_payload,
   // result output
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output mqrf_pkg::status_type                  rsp_status,
   output logic [DATA_WIDTH-1:0]                 rsp_read_data,
   output logic [$clog2(MAX_DEPTH+1)-1:0]        rsp_fill_level,
   // configuration
   input  wire logic                             csr_we,
   input  wire logic [mqrf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mqrf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mqrf_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
   localparam int ADDR_W = $clog2(NUM_QUEUES * MAX_DEPTH);

   op_type              op;
   logic [CNT_W-1:0]    level;
   logic [ADDR_W-1:0]   addr;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic                accept;
   logic                s1_move;

   logic                s1_valid_ff, s1_valid_in;
   status_type          s1_status_ff;
   logic                s1_rd_ff;
   logic [CNT_W-1:0]    s1_level_ff;

   logic                out_valid_ff, out_valid_in;
   status_type          out_status_ff;
   logic [DATA_WIDTH-1:0] out_data_ff;
   logic [CNT_W-1:0]    out_level_ff;

   // handshake
   assign s1_move   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // queue bookkeeping
   mqrf_ctrl #(
      .NUM_QUEUES (NUM_QUEUES),
      .MAX_DEPTH  (MAX_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_kind     (req_kind),
      .req_queue_id (req_queue_id),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .op           (op),
      .level        (level),
      .addr         (addr)
   );

   // shared word store
   mqrf_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (NUM_QUEUES * MAX_DEPTH)
   ) u_store (
      .clock (clock),
      .en    (op.mem_en),
      .we    (op.mem_we),
      .addr  (addr),
      .wdata (req_payload),
      .rdata (ram_rdata)
   );

   // valid bits of the stage and output registers
   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage register: result while the store read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= op.status;
         s1_rd_ff     <= op.rd_ok;
         s1_level_ff  <= level;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_status_ff <= s1_status_ff;
         out_data_ff   <= s1_rd_ff ? ram_rdata : '0;
         out_level_ff  <= s1_level_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_read_data  = out_data_ff;
   assign rsp_fill_level = out_level_ff;

endmodule
`default_nettype wire
